>>> rtl/imhq_pkg.sv
package imhq_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_SPACE = 64;
    localparam int IDX_W     = 6;
    localparam int CNT_W     = 7;
    localparam int KEY_W     = 6;
    localparam int VAL_W     = 32;
    localparam int ENT_W     = VAL_W + KEY_W;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 56;

    typedef enum logic [1:0] {
        MODE_PUSH   = 2'd0,
        MODE_UPDATE = 2'd1,
        MODE_POP    = 2'd2,
        MODE_NOP    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        STAT_DONE   = 3'd0,
        STAT_ABSENT = 3'd1,
        STAT_EMPTY  = 3'd2,
        STAT_FULL   = 3'd3,
        STAT_DUP    = 3'd4
    } status_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_IDLE,
        OP_REJECT,
        OP_PUSH,
        OP_UPD_LOOK,
        OP_UPD_SET,
        OP_POP_RD,
        OP_POP_SW,
        OP_DN_RD,
        OP_DN_CMP,
        OP_DN_WR,
        OP_RELOAD_RD,
        OP_RELOAD,
        OP_UP_RD,
        OP_UP_CMP,
        OP_UP_WR,
        OP_TOP_RD,
        OP_OUT
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_UPD_SET,
        ST_POP_SW,
        ST_DN_RD,
        ST_DN_CMP,
        ST_DN_WR,
        ST_RELOAD_RD,
        ST_RELOAD,
        ST_UP_RD,
        ST_UP_CMP,
        ST_UP_WR,
        ST_TOP_RD,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic  accept;
        logic  refuse;
        mode_t mode;
        logic  dn_move;
        logic  up_move;
        logic  i_zero;
        logic  out_free;
    } dp_stat_t;

endpackage

>>> rtl/imhq_ctrl.sv
module imhq_ctrl
    import imhq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (stat.accept) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                if (stat.refuse) begin
                    state_next = ST_TOP_RD;
                end else begin
                    case (stat.mode)
                        MODE_PUSH:   state_next = ST_UP_RD;
                        MODE_UPDATE: state_next = ST_UPD_SET;
                        MODE_POP:    state_next = ST_POP_SW;
                        default:     state_next = ST_TOP_RD;
                    endcase
                end
            end
            ST_UPD_SET:   state_next = ST_DN_RD;
            ST_POP_SW:    state_next = ST_DN_RD;
            ST_DN_RD:     state_next = ST_DN_CMP;
            ST_DN_CMP: begin
                if (stat.dn_move) begin
                    state_next = ST_DN_WR;
                end else if (stat.mode == MODE_UPDATE) begin
                    state_next = ST_RELOAD_RD;
                end else begin
                    state_next = ST_TOP_RD;
                end
            end
            ST_DN_WR:     state_next = ST_DN_RD;
            ST_RELOAD_RD: state_next = ST_RELOAD;
            ST_RELOAD:    state_next = ST_UP_RD;
            ST_UP_RD:     state_next = stat.i_zero ? ST_TOP_RD : ST_UP_CMP;
            ST_UP_CMP:    state_next = stat.up_move ? ST_UP_WR : ST_TOP_RD;
            ST_UP_WR:     state_next = ST_UP_RD;
            ST_TOP_RD:    state_next = ST_OUT;
            ST_OUT: begin
                if (stat.out_free) state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd.op = OP_NONE;
        case (state_reg)
            ST_IDLE:      cmd.op = OP_IDLE;
            ST_DECODE: begin
                if (stat.refuse) begin
                    cmd.op = OP_REJECT;
                end else begin
                    case (stat.mode)
                        MODE_PUSH:   cmd.op = OP_PUSH;
                        MODE_UPDATE: cmd.op = OP_UPD_LOOK;
                        MODE_POP:    cmd.op = OP_POP_RD;
                        default:     cmd.op = OP_NONE;
                    endcase
                end
            end
            ST_UPD_SET:   cmd.op = OP_UPD_SET;
            ST_POP_SW:    cmd.op = OP_POP_SW;
            ST_DN_RD:     cmd.op = OP_DN_RD;
            ST_DN_CMP:    cmd.op = OP_DN_CMP;
            ST_DN_WR:     cmd.op = OP_DN_WR;
            ST_RELOAD_RD: cmd.op = OP_RELOAD_RD;
            ST_RELOAD:    cmd.op = OP_RELOAD;
            ST_UP_RD:     cmd.op = OP_UP_RD;
            ST_UP_CMP:    cmd.op = OP_UP_CMP;
            ST_UP_WR:     cmd.op = OP_UP_WR;
            ST_TOP_RD:    cmd.op = OP_TOP_RD;
            ST_OUT:       cmd.op = OP_OUT;
            default:      cmd.op = OP_NONE;
        endcase
    end

endmodule

>>> rtl/imhq_dp.sv
module imhq_dp
    import imhq_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    logic [ENT_W-1:0] heap_mem [CAPACITY];
    logic [IDX_W-1:0] pos_mem  [KEY_SPACE];

    logic [ENT_W-1:0] rda_reg, rdb_reg;
    logic [IDX_W-1:0] pos_rd_reg;

    logic [IDX_W-1:0] raddr_a, raddr_b, waddr, pos_waddr_idx;
    logic [KEY_W-1:0] pos_waddr;
    logic [IDX_W-1:0] pos_wdata;
    logic [ENT_W-1:0] wdata;
    logic             we, pos_we;

    mode_t                    mode_reg;
    logic [KEY_W-1:0]         key_reg;
    logic signed [VAL_W-1:0]  val_reg;
    status_t                  status_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [IDX_W-1:0]         i_reg, i0_reg, tgt_reg;
    logic signed [VAL_W-1:0]  cur_val_reg;
    logic [KEY_W-1:0]         cur_key_reg;
    logic [KEY_SPACE-1:0]     present_reg;

    logic                     m_valid_reg;
    logic [M_DATA_W-1:0]      m_data_reg;

    logic                     accept;
    logic signed [VAL_W-1:0]  a_val, b_val, best_val;
    logic [KEY_W-1:0]         a_key, b_key, best_key;
    logic [IDX_W-1:0]         best_idx, par_idx;
    logic [CNT_W:0]           l_idx, r_idx, cnt_ext;
    logic                     l_ok, r_ok, dn_move, up_move;
    logic                     refuse;
    status_t                  refuse_code;
    logic                     empty;

    function automatic logic pair_less(logic signed [VAL_W-1:0] v1, logic [KEY_W-1:0] k1,
                                       logic signed [VAL_W-1:0] v2, logic [KEY_W-1:0] k2);
        if (v1 != v2) begin
            return v1 < v2;
        end
        return k1 < k2;
    endfunction

    assign s_tready = (cmd.op == OP_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign a_val = $signed(rda_reg[ENT_W-1:KEY_W]);
    assign a_key = rda_reg[KEY_W-1:0];
    assign b_val = $signed(rdb_reg[ENT_W-1:KEY_W]);
    assign b_key = rdb_reg[KEY_W-1:0];

    assign l_idx   = {1'b0, i_reg, 1'b1};
    assign r_idx   = l_idx + (CNT_W+1)'(1);
    assign cnt_ext = {1'b0, cnt_reg};
    assign l_ok    = l_idx < cnt_ext;
    assign r_ok    = r_idx < cnt_ext;
    assign par_idx = (i_reg - IDX_W'(1)) >> 1;
    assign empty   = (cnt_reg == '0);

    always_comb begin
        best_val = cur_val_reg;
        best_key = cur_key_reg;
        best_idx = i_reg;
        dn_move  = 1'b0;
        if (l_ok && pair_less(a_val, a_key, best_val, best_key)) begin
            best_val = a_val;
            best_key = a_key;
            best_idx = l_idx[IDX_W-1:0];
            dn_move  = 1'b1;
        end
        if (r_ok && pair_less(b_val, b_key, best_val, best_key)) begin
            best_val = b_val;
            best_key = b_key;
            best_idx = r_idx[IDX_W-1:0];
            dn_move  = 1'b1;
        end
    end

    assign up_move = a_val > cur_val_reg;

    always_comb begin
        refuse      = 1'b0;
        refuse_code = STAT_DONE;
        case (mode_reg)
            MODE_PUSH: begin
                if (cnt_reg == CNT_W'(CAPACITY)) begin
                    refuse      = 1'b1;
                    refuse_code = STAT_FULL;
                end else if (present_reg[key_reg]) begin
                    refuse      = 1'b1;
                    refuse_code = STAT_DUP;
                end
            end
            MODE_UPDATE: begin
                if (!present_reg[key_reg]) begin
                    refuse      = 1'b1;
                    refuse_code = STAT_ABSENT;
                end
            end
            MODE_POP: begin
                if (empty) begin
                    refuse      = 1'b1;
                    refuse_code = STAT_EMPTY;
                end
            end
            default: refuse = 1'b0;
        endcase
    end

    always_comb begin
        raddr_a       = '0;
        raddr_b       = '0;
        we            = 1'b0;
        waddr         = '0;
        wdata         = '0;
        pos_we        = 1'b0;
        pos_waddr     = '0;
        pos_waddr_idx = '0;
        case (cmd.op)
            OP_PUSH: begin
                we            = 1'b1;
                waddr         = cnt_reg[IDX_W-1:0];
                wdata         = {val_reg, key_reg};
                pos_we        = 1'b1;
                pos_waddr     = key_reg;
                pos_waddr_idx = cnt_reg[IDX_W-1:0];
            end
            OP_UPD_SET: begin
                we    = 1'b1;
                waddr = pos_rd_reg;
                wdata = {val_reg, key_reg};
            end
            OP_POP_RD: begin
                raddr_b = IDX_W'(cnt_reg - CNT_W'(1));
            end
            OP_POP_SW: begin
                we        = 1'b1;
                wdata     = rdb_reg;
                pos_we    = 1'b1;
                pos_waddr = b_key;
            end
            OP_DN_RD: begin
                raddr_a = l_idx[IDX_W-1:0];
                raddr_b = r_idx[IDX_W-1:0];
            end
            OP_DN_CMP: begin
                if (dn_move) begin
                    we            = 1'b1;
                    waddr         = i_reg;
                    wdata         = {best_val, best_key};
                    pos_we        = 1'b1;
                    pos_waddr     = best_key;
                    pos_waddr_idx = i_reg;
                end
            end
            OP_DN_WR, OP_UP_WR: begin
                we            = 1'b1;
                waddr         = tgt_reg;
                wdata         = {cur_val_reg, cur_key_reg};
                pos_we        = 1'b1;
                pos_waddr     = cur_key_reg;
                pos_waddr_idx = tgt_reg;
            end
            OP_RELOAD_RD: begin
                raddr_a = i0_reg;
            end
            OP_UP_RD: begin
                raddr_a = par_idx;
            end
            OP_UP_CMP: begin
                if (up_move) begin
                    we            = 1'b1;
                    waddr         = i_reg;
                    wdata         = rda_reg;
                    pos_we        = 1'b1;
                    pos_waddr     = a_key;
                    pos_waddr_idx = i_reg;
                end
            end
            default: raddr_a = '0;
        endcase
    end

    assign pos_wdata = pos_waddr_idx;

    always_ff @(posedge aclk) begin
        if (we) heap_mem[waddr] <= wdata;
        rda_reg <= heap_mem[raddr_a];
        rdb_reg <= heap_mem[raddr_b];
    end

    always_ff @(posedge aclk) begin
        if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
        pos_rd_reg <= pos_mem[key_reg];
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg   <= mode_t'(s_tdata[1:0]);
            key_reg    <= s_tdata[7:2];
            val_reg    <= $signed(s_tdata[39:8]);
            status_reg <= STAT_DONE;
        end
        case (cmd.op)
            OP_REJECT:    status_reg <= refuse_code;
            OP_PUSH: begin
                cur_val_reg <= val_reg;
                cur_key_reg <= key_reg;
                i_reg       <= cnt_reg[IDX_W-1:0];
            end
            OP_UPD_SET: begin
                i_reg       <= pos_rd_reg;
                i0_reg      <= pos_rd_reg;
                cur_val_reg <= val_reg;
                cur_key_reg <= key_reg;
            end
            OP_POP_SW: begin
                cur_val_reg <= b_val;
                cur_key_reg <= b_key;
                i_reg       <= '0;
            end
            OP_DN_CMP:    tgt_reg <= best_idx;
            OP_DN_WR:     i_reg <= tgt_reg;
            OP_RELOAD_RD: i_reg <= i0_reg;
            OP_RELOAD: begin
                cur_val_reg <= a_val;
                cur_key_reg <= a_key;
            end
            OP_UP_CMP:    tgt_reg <= par_idx;
            OP_UP_WR:     i_reg <= tgt_reg;
            default:      tgt_reg <= tgt_reg;
        endcase
        if (cmd.op == OP_OUT && (!m_valid_reg || m_tready)) begin
            m_data_reg <= {{(M_DATA_W-CNT_W-VAL_W-KEY_W-4){1'b0}},
                           cnt_reg,
                           empty,
                           empty ? {1'b1, {(VAL_W-1){1'b0}}} : a_val,
                           empty ? KEY_W'(0) : a_key,
                           status_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            present_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.op == OP_PUSH) begin
                present_reg[key_reg] <= 1'b1;
                cnt_reg              <= cnt_reg + CNT_W'(1);
            end
            if (cmd.op == OP_POP_SW) begin
                present_reg[a_key] <= 1'b0;
                cnt_reg            <= cnt_reg - CNT_W'(1);
            end
            if (cmd.op == OP_OUT && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign stat.accept   = accept;
    assign stat.refuse   = refuse;
    assign stat.mode     = mode_reg;
    assign stat.dn_move  = dn_move;
    assign stat.up_move  = up_move;
    assign stat.i_zero   = (i_reg == '0);
    assign stat.out_free = !m_valid_reg || m_tready;

endmodule

>>> rtl/indexed_min_heap_queue.sv
// Indexed binary min-heap priority queue of up to 64 (value, key) entries.
// Input channel s_*: one item is one operation: push a new key with its value,
// update the value of a key already held, or pop the minimum entry.
// Result channel m_*: exactly one item per operation, giving the status, the
// key and value at the top of the heap, an empty flag and the entry count.
// Refused operations leave the queue unchanged and report why in the status.
// A refused item or an unused mode goes from decode straight to the top read
// and the result. Each heap level that an entry moves adds one registered
// read of the single heap memory, a compare and two writes through its one
// write port. The next item can be accepted in the cycle in which the result
// of the last one appears.
// Only one item is in work at a time; s_tready is high while the block idles,
// even when a finished result still waits in the output register.
// If the receiver stalls, the result holds in the output register and the
// next item finishes only up to that register before it waits.
// Reset empties the queue at once and drops any pending result.
module indexed_min_heap_queue
    import imhq_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // mode[1:0], key[7:2], value[39:8]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // status[2:0], top_key[8:3], top_value[40:9],
                                           // is_empty[41], entry_count[48:42]
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    imhq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .cmd     (cmd)
    );

    imhq_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> rtl/imhq_checker.sv
module imhq_checker
    import imhq_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_DATA_W-1:0] s_tdata,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_empty_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[41] == (m_tdata[48:42] == 7'd0)))
        else $error("empty flag disagrees with entry count");

    a_empty_top_key: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[41]) |-> (m_tdata[8:3] == 6'd0))
        else $error("top key not zero on empty queue");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[48:42] <= 7'd64))
        else $error("entry count beyond capacity");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind indexed_min_heap_queue imhq_checker u_imhq_checker (.*);
